// File: rtl/plg_pkg.sv
package plg_pkg;

    // Default coordinate width (signed Q16.16 at 32 bits).
    localparam int COORD_BITS_DEF = 32;

    // Projection parameter t: unsigned magnitude with 32 fraction bits.
    localparam int TQ_W      = 63;
    localparam int T_FRAC    = 32;
    localparam logic [TQ_W-1:0] T_ONE = TQ_W'(64'h0000_0001_0000_0000);
    localparam logic [TQ_W-1:0] T_CAP = TQ_W'(64'h4000_0000_0000_0000);

    // Offset vector components saturate to 63-bit magnitudes.
    localparam int DV_W = 63;
    localparam logic [DV_W-1:0] DV_CAP = '1;

    // Sum of squares and its integer root.
    localparam int RT_W = 64;
    localparam int SQ_W = 2 * RT_W;

    // Reset value of line_x: one in Q16.16.
    localparam int LINE_X_RST = 65536;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_X   = 2'd0,
        CFG_LINE_Y   = 2'd1,
        CFG_LINE_Z   = 2'd2,
        CFG_INF_MODE = 2'd3
    } t_cfg_idx;

endpackage

// File: rtl/plg_if.sv
interface plg_in_if #(
    parameter int COORD_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic signed [COORD_BITS-1:0] vel_x;
    logic signed [COORD_BITS-1:0] vel_y;
    logic signed [COORD_BITS-1:0] vel_z;

    modport source (output valid, point_x, point_y, point_z, vel_x, vel_y, vel_z,
                    input ready);
    modport sink   (input valid, point_x, point_y, point_z, vel_x, vel_y, vel_z,
                    output ready);
endinterface

interface plg_out_if #(
    parameter int COORD_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic        [COORD_BITS-1:0] distance;
    logic signed [COORD_BITS-1:0] grad_entry;
    logic                         grad_valid;

    modport source (output valid, distance, grad_entry, grad_valid, input ready);
    modport sink   (input valid, distance, grad_entry, grad_valid, output ready);
endinterface

interface plg_cfg_if #(
    parameter int COORD_BITS = 32
);
    logic                  valid;
    logic                  ready;
    plg_pkg::t_cfg_idx     index;
    logic [COORD_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/plg_div_pipe.sv
module plg_div_pipe #(
    parameter int DW = 64,
    parameter int QW = 32,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rem0,
    input  logic [DW-1:0] i_div,
    input  logic [QW-1:0] i_num,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    // Restoring division, one quotient bit per stage. The numerator bits still
    // to be consumed and the quotient bits already produced share one register.
    logic          r_vld  [QW];
    logic [DW-1:0] r_rem  [QW];
    logic [DW-1:0] r_div  [QW];
    logic [QW-1:0] r_nq   [QW];
    logic [SW-1:0] r_side [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stg
        logic          v_in;
        logic [DW-1:0] rem_in;
        logic [DW-1:0] div_in;
        logic [QW-1:0] nq_in;
        logic [SW-1:0] side_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] n_rem;
        logic [QW-1:0] n_nq;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = i_rem0;
            assign div_in  = i_div;
            assign nq_in   = i_num;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_vld[k-1];
            assign rem_in  = r_rem[k-1];
            assign div_in  = r_div[k-1];
            assign nq_in   = r_nq[k-1];
            assign side_in = r_side[k-1];
        end

        assign trial = {rem_in, nq_in[QW-1]};
        assign diff  = trial - {1'b0, div_in};
        assign ge    = trial >= {1'b0, div_in};
        assign n_rem = ge ? diff[DW-1:0] : trial[DW-1:0];
        assign n_nq  = {nq_in[QW-2:0], ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_div[k]  <= div_in;
                r_nq[k]   <= n_nq;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_nq[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

// File: rtl/plg_sqrt_pipe.sv
module plg_sqrt_pipe #(
    parameter int RW = 64,
    parameter int SW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [2*RW-1:0] i_num,
    input  logic [SW-1:0]   i_side,
    output logic            o_valid,
    output logic [RW-1:0]   o_root,
    output logic [SW-1:0]   o_side
);

    // Digit-by-digit integer square root, one root bit per stage. Two radicand
    // bits enter the partial remainder at each stage.
    logic            r_vld  [RW];
    logic [RW-1:0]   r_rem  [RW];
    logic [RW-1:0]   r_root [RW];
    logic [2*RW-1:0] r_num  [RW];
    logic [SW-1:0]   r_side [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stg
        logic            v_in;
        logic [RW-1:0]   rem_in;
        logic [RW-1:0]   root_in;
        logic [2*RW-1:0] num_in;
        logic [SW-1:0]   side_in;
        logic [RW+1:0]   trial;
        logic [RW+1:0]   cand;
        logic [RW+1:0]   diff;
        logic            ge;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign num_in  = i_num;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_vld[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign num_in  = r_num[k-1];
            assign side_in = r_side[k-1];
        end

        assign trial = {rem_in, num_in[2*RW-1:2*RW-2]};
        assign cand  = {root_in, 2'b01};
        assign diff  = trial - cand;
        assign ge    = trial >= cand;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? diff[RW-1:0] : trial[RW-1:0];
                r_root[k] <= {root_in[RW-2:0], ge};
                r_num[k]  <= {num_in[2*RW-3:0], 2'b00};
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_vld[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_side  = r_side[RW-1];

endmodule

// File: rtl/point_line_distance_gradient.sv
// Throughput: one item per cycle while the output side does not stall; the two
//   dividers and the root are fully pipelined.
// Reset (i_rst_n low at a clock edge, synchronous): the pipeline empties and the
//   line registers return to (1.0, 0, 0) with segment mode selected.
module point_line_distance_gradient #(
    parameter int COORD_BITS = plg_pkg::COORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    plg_in_if.sink    i_in,
    plg_out_if.source o_out,
    plg_cfg_if.sink   i_cfg
);
    import plg_pkg::*;

    localparam int W      = COORD_BITS;
    localparam int NM_W   = 2 * W;          // |P.L| and L.L
    localparam int NS_W   = 2 * W + 3;      // signed P.L
    localparam int TH_W   = TQ_W - 32;      // upper slice of t
    localparam int PF_W   = W + TQ_W;       // full t*L product
    localparam int PRD_W  = W + 31;         // t*L rounded to Q16.16
    localparam int DVS_W  = W + 33;         // signed offset component
    localparam int SQI_W  = 2 * DV_W;       // one squared component
    localparam int DI_W   = W + DV_W;       // one dot product term
    localparam int DOT_W  = W + 64;         // |dv.V|
    localparam int DOTS_W = W + 66;         // signed dv.V

    typedef struct packed {
        logic [2:0][W-1:0] pm;
        logic [2:0]        pn;
        logic [2:0][W-1:0] vm;
        logic [2:0]        vn;
    } t_item;

    typedef struct packed {
        t_item it;
        logic  nneg;
        logic  nzero;
        logic  dzero;
        logic  ovf;
    } t_tdiv;

    typedef struct packed {
        logic [DOT_W-1:0] dotm;
        logic             dneg;
        logic             sqz;
    } t_sqs;

    typedef struct packed {
        logic [RT_W-1:0] root;
        logic            dneg;
        logic            sqz;
        logic            ovf;
    } t_gds;

    // The whole pipeline advances together. It moves whenever the output
    // register is empty or its result is being transferred this cycle, so no
    // new item is taken while a finished result waits.
    logic en;
    logic r_vout;
    assign en          = !r_vout || o_out.ready;
    assign i_in.ready  = en;
    assign i_cfg.ready = 1'b1;

    // ---------------------------------------------------------------
    // Configuration registers. L.L is refreshed every cycle from them;
    // r_d is first used at the entry of the t divider, beside stage 4.
    // ---------------------------------------------------------------
    logic [2:0][W-1:0] r_line;
    logic              r_inf;
    logic [NM_W-1:0]   r_d;
    logic [2:0][W-1:0] lm;
    logic [2:0]        ln;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line[0] <= W'(LINE_X_RST);
            r_line[1] <= '0;
            r_line[2] <= '0;
            r_inf     <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_LINE_X:   r_line[0] <= i_cfg.data;
                CFG_LINE_Y:   r_line[1] <= i_cfg.data;
                CFG_LINE_Z:   r_line[2] <= i_cfg.data;
                CFG_INF_MODE: r_inf     <= i_cfg.data[0];
                default:      r_inf     <= r_inf;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ln[i] = r_line[i][W-1];
            lm[i] = ln[i] ? W'(~r_line[i] + 1'b1) : r_line[i];
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= NM_W'(lm[0] * lm[0]) + NM_W'(lm[1] * lm[1]) + NM_W'(lm[2] * lm[2]);
    end

    // ---------------------------------------------------------------
    // Stage 1: split every input field into sign and magnitude.
    // ---------------------------------------------------------------
    logic [5:0][W-1:0] in_raw;
    t_item             n_it1;
    logic              r_v1;
    t_item             r_it1;

    assign in_raw[0] = i_in.point_x;
    assign in_raw[1] = i_in.point_y;
    assign in_raw[2] = i_in.point_z;
    assign in_raw[3] = i_in.vel_x;
    assign in_raw[4] = i_in.vel_y;
    assign in_raw[5] = i_in.vel_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_it1.pn[i] = in_raw[i][W-1];
            n_it1.pm[i] = n_it1.pn[i] ? W'(~in_raw[i] + 1'b1) : in_raw[i];
            n_it1.vn[i] = in_raw[3+i][W-1];
            n_it1.vm[i] = n_it1.vn[i] ? W'(~in_raw[3+i] + 1'b1) : in_raw[3+i];
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: the three products of P.L.
    // Stage 3: their signed sum.
    // Stage 4: magnitude and sign of P.L.
    // ---------------------------------------------------------------
    logic                   r_v2, r_v3, r_v4;
    t_item                  r_it2, r_it3, r_it4;
    logic [2:0][NM_W-1:0]   r_pl2;
    logic [2:0]             r_ps2;
    logic signed [NS_W-1:0] r_n3;
    logic signed [NS_W-1:0] term3 [3];
    logic [NS_W-1:0]        abs4;
    logic [NM_W-1:0]        r_nmag4;
    logic                   r_nneg4;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            term3[i] = r_ps2[i] ? -$signed({3'b000, r_pl2[i]}) : $signed({3'b000, r_pl2[i]});
        end
    end

    assign abs4 = r_n3[NS_W-1] ? NS_W'(-r_n3) : NS_W'(r_n3);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_it1 <= n_it1;
            r_it2 <= r_it1;
            for (int i = 0; i < 3; i++) begin
                r_pl2[i] <= NM_W'(r_it1.pm[i] * lm[i]);
                r_ps2[i] <= r_it1.pn[i] ^ ln[i];
            end
            r_it3   <= r_it2;
            r_n3    <= term3[0] + term3[1] + term3[2];
            r_it4   <= r_it3;
            r_nmag4 <= abs4[NM_W-1:0];
            r_nneg4 <= r_n3[NS_W-1];
        end
    end

    // ---------------------------------------------------------------
    // t = |P.L| * 2^32 / L.L, one quotient bit per stage. The quotient
    // needs 63 bits; anything at or above 2^63 is flagged as overflow
    // before the division starts and saturates afterwards.
    // ---------------------------------------------------------------
    t_tdiv           d1_side_i;
    t_tdiv           d1_side_o;
    logic            d1_valid;
    logic [TQ_W-1:0] d1_quo;

    assign d1_side_i.it    = r_it4;
    assign d1_side_i.nneg  = r_nneg4;
    assign d1_side_i.nzero = (r_nmag4 == '0);
    assign d1_side_i.dzero = (r_d == '0);
    assign d1_side_i.ovf   = (r_nmag4 >> 31) >= r_d;

    plg_div_pipe #(
        .DW (NM_W),
        .QW (TQ_W),
        .SW ($bits(t_tdiv))
    ) u_tdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v4),
        .i_rem0  (r_nmag4 >> 31),
        .i_div   (r_d),
        .i_num   ({r_nmag4[30:0], {T_FRAC{1'b0}}}),
        .i_side  (d1_side_i),
        .o_valid (d1_valid),
        .o_quo   (d1_quo),
        .o_side  (d1_side_o)
    );

    // ---------------------------------------------------------------
    // Stage 5: clamp t. A zero line or a point on the normal plane gives
    // t = 0. Segment mode clamps to [0,1]; the infinite line caps |t|.
    // ---------------------------------------------------------------
    logic [TQ_W-1:0] n_tq5;
    logic            n_tneg5;
    logic [TQ_W-1:0] r_tq5;
    logic            r_tneg5;
    logic            r_v5;
    t_item           r_it5;

    always_comb begin
        n_tq5   = '0;
        n_tneg5 = 1'b0;
        if (!d1_side_o.dzero && !d1_side_o.nzero) begin
            if (r_inf) begin
                n_tq5   = (d1_side_o.ovf || d1_quo > T_CAP) ? T_CAP : d1_quo;
                n_tneg5 = d1_side_o.nneg;
            end else if (!d1_side_o.nneg) begin
                n_tq5   = (d1_side_o.ovf || d1_quo > T_ONE) ? T_ONE : d1_quo;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 6: t*L as two partial products per component.
    // Stage 7: recombine and round to Q16.16, halves away from zero.
    // Stage 8: dv = t*L - P, signed.
    // Stage 9: magnitude of dv, saturated to 63 bits.
    // ---------------------------------------------------------------
    logic                    r_v6, r_v7, r_v8, r_v9;
    t_item                   r_it6, r_it7, r_it8, r_it9;
    logic [2:0][31+W:0]      r_plo6;
    logic [2:0][TH_W+W-1:0]  r_phi6;
    logic [2:0]              r_sg6, r_sg7;
    logic [PF_W-1:0]         pfull7 [3];
    logic [2:0][PRD_W-1:0]   r_prod7;
    logic signed [DVS_W-1:0] sp8 [3];
    logic signed [DVS_W-1:0] pp8 [3];
    logic [2:0][DVS_W-1:0]   r_dv8;
    logic [DVS_W+DV_W-1:0]   mag9 [3];
    logic [2:0][DV_W-1:0]    r_dvm9;
    logic [2:0]              r_dvn9;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pfull7[i] = PF_W'(r_plo6[i]) + PF_W'({r_phi6[i], 32'h0}) + PF_W'(64'h8000_0000);
            sp8[i]    = r_sg7[i] ? -$signed({2'b00, r_prod7[i]})
                                 : $signed({2'b00, r_prod7[i]});
            pp8[i]    = r_it7.pn[i] ? -$signed({33'h0, r_it7.pm[i]})
                                    : $signed({33'h0, r_it7.pm[i]});
            mag9[i]   = (DVS_W+DV_W)'(r_dv8[i][DVS_W-1] ? DVS_W'(-$signed(r_dv8[i]))
                                                      : r_dv8[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tq5   <= n_tq5;
            r_tneg5 <= n_tneg5;
            r_it5   <= d1_side_o.it;
            r_it6   <= r_it5;
            r_it7   <= r_it6;
            r_it8   <= r_it7;
            r_it9   <= r_it8;
            r_sg7   <= r_sg6;
            for (int i = 0; i < 3; i++) begin
                r_plo6[i]  <= (32+W)'(r_tq5[31:0] * lm[i]);
                r_phi6[i]  <= (TH_W+W)'(r_tq5[TQ_W-1:32] * lm[i]);
                r_sg6[i]   <= r_tneg5 ^ ln[i];
                r_prod7[i] <= pfull7[i][PF_W-1:32];
                r_dv8[i]   <= sp8[i] - pp8[i];
                r_dvm9[i]  <= (mag9[i] > (DVS_W+DV_W)'(DV_CAP)) ? DV_CAP : mag9[i][DV_W-1:0];
                r_dvn9[i]  <= r_dv8[i][DVS_W-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 10: partial products of dv.dv and dv.V.
    // Stage 11: recombine per component.
    // Stage 12: sum of squares and signed dot product.
    // Stage 13: magnitude and sign of the dot product.
    // ---------------------------------------------------------------
    logic                    r_v10, r_v11, r_v12, r_v13;
    logic [2:0][63:0]        r_ll10;
    logic [2:0][62:0]        r_lh10;
    logic [2:0][61:0]        r_hh10;
    logic [2:0][31+W:0]      r_dl10;
    logic [2:0][30+W:0]      r_dh10;
    logic [2:0]              r_ds10, r_ds11;
    logic [2:0][SQI_W-1:0]   r_sqi11;
    logic [2:0][DI_W-1:0]    r_di11;
    logic signed [DOTS_W-1:0] dterm12 [3];
    logic [SQ_W-1:0]         r_sq12, r_sq13;
    logic signed [DOTS_W-1:0] r_dot12;
    logic [DOTS_W-1:0]       dabs13;
    t_sqs                    r_sqs13;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dterm12[i] = r_ds11[i] ? -$signed({3'b000, r_di11[i]})
                                   : $signed({3'b000, r_di11[i]});
        end
    end

    assign dabs13 = r_dot12[DOTS_W-1] ? DOTS_W'(-r_dot12) : DOTS_W'(r_dot12);

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_ll10[i]  <= 64'(r_dvm9[i][31:0] * r_dvm9[i][31:0]);
                r_lh10[i]  <= 63'(r_dvm9[i][31:0] * r_dvm9[i][DV_W-1:32]);
                r_hh10[i]  <= 62'(r_dvm9[i][DV_W-1:32] * r_dvm9[i][DV_W-1:32]);
                r_dl10[i]  <= (32+W)'(r_dvm9[i][31:0] * r_it9.vm[i]);
                r_dh10[i]  <= (31+W)'(r_dvm9[i][DV_W-1:32] * r_it9.vm[i]);
                r_ds10[i]  <= r_dvn9[i] ^ r_it9.vn[i];
                r_sqi11[i] <= SQI_W'(r_ll10[i]) + SQI_W'({r_lh10[i], 33'h0})
                            + SQI_W'({r_hh10[i], 64'h0});
                r_di11[i]  <= DI_W'(r_dl10[i]) + DI_W'({r_dh10[i], 32'h0});
            end
            r_ds11  <= r_ds10;
            r_sq12  <= SQ_W'(r_sqi11[0]) + SQ_W'(r_sqi11[1]) + SQ_W'(r_sqi11[2]);
            r_dot12 <= dterm12[0] + dterm12[1] + dterm12[2];
            r_sq13  <= r_sq12;
            r_sqs13.dotm <= dabs13[DOT_W-1:0];
            r_sqs13.dneg <= r_dot12[DOTS_W-1];
            r_sqs13.sqz  <= (r_sq12 == '0);
        end
    end

    // ---------------------------------------------------------------
    // Floor square root of the sum of squares, one bit per stage.
    // ---------------------------------------------------------------
    logic            sq_valid;
    logic [RT_W-1:0] sq_root;
    t_sqs            sq_side;
    t_gds            d2_side_i;
    t_gds            d2_side_o;
    logic            d2_valid;
    logic [W-1:0]    d2_quo;

    plg_sqrt_pipe #(
        .RW (RT_W),
        .SW ($bits(t_sqs))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v13),
        .i_num   (r_sq13),
        .i_side  (r_sqs13),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // ---------------------------------------------------------------
    // |dv.V| / root, truncating. Only COORD_BITS quotient bits are formed;
    // a larger quotient is flagged up front and saturates at the output.
    // A zero root (zero distance) lands in the overflow case and is masked.
    // ---------------------------------------------------------------
    assign d2_side_i.root = sq_root;
    assign d2_side_i.dneg = sq_side.dneg;
    assign d2_side_i.sqz  = sq_side.sqz;
    assign d2_side_i.ovf  = sq_side.dotm[DOT_W-1:W] >= sq_root;

    plg_div_pipe #(
        .DW (RT_W),
        .QW (W),
        .SW ($bits(t_gds))
    ) u_gdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_rem0  (sq_side.dotm[DOT_W-1:W]),
        .i_div   (sq_root),
        .i_num   (sq_side.dotm[W-1:0]),
        .i_side  (d2_side_i),
        .o_valid (d2_valid),
        .o_quo   (d2_quo),
        .o_side  (d2_side_o)
    );

    // ---------------------------------------------------------------
    // Output register. The gradient entry is the negated quotient, so a
    // positive dot product gives a negative entry; it saturates at the
    // signed range. The distance saturates at the unsigned range.
    // ---------------------------------------------------------------
    logic         gneg;
    logic [W-1:0] glim;
    logic [W-1:0] gmag;
    logic [W-1:0] r_dist;
    logic [W-1:0] r_grad;
    logic         r_gv;

    assign gneg = !d2_side_o.dneg && (d2_side_o.ovf || d2_quo != '0);
    assign glim = gneg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    assign gmag = (d2_side_o.ovf || d2_quo > glim) ? glim : d2_quo;

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (d2_side_o.sqz) begin
                r_dist <= '0;
                r_grad <= '0;
                r_gv   <= 1'b0;
            end else begin
                r_dist <= (d2_side_o.root[RT_W-1:W] != '0) ? '1 : d2_side_o.root[W-1:0];
                r_grad <= gneg ? W'(~gmag + 1'b1) : gmag;
                r_gv   <= 1'b1;
            end
        end
    end

    // Valid bits of the stages outside the arithmetic units.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_v5   <= 1'b0;
            r_v6   <= 1'b0;
            r_v7   <= 1'b0;
            r_v8   <= 1'b0;
            r_v9   <= 1'b0;
            r_v10  <= 1'b0;
            r_v11  <= 1'b0;
            r_v12  <= 1'b0;
            r_v13  <= 1'b0;
            r_vout <= 1'b0;
        end else if (en) begin
            r_v1   <= i_in.valid;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_v4   <= r_v3;
            r_v5   <= d1_valid;
            r_v6   <= r_v5;
            r_v7   <= r_v6;
            r_v8   <= r_v7;
            r_v9   <= r_v8;
            r_v10  <= r_v9;
            r_v11  <= r_v10;
            r_v12  <= r_v11;
            r_v13  <= r_v12;
            r_vout <= d2_valid;
        end
    end

    assign o_out.valid      = r_vout;
    assign o_out.distance   = r_dist;
    assign o_out.grad_entry = r_grad;
    assign o_out.grad_valid = r_gv;

`ifndef SYNTHESIS
    a_zero_dist_no_grad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.grad_valid) |-> (o_out.distance == '0 && o_out.grad_entry == '0))
        else $error("zero-distance result carries a gradient");
    a_grad_has_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.grad_valid) |-> (o_out.distance != '0))
        else $error("gradient flagged valid with zero distance");
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result present right after reset");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vout && !o_out.ready) |=> (r_vout && $stable(r_dist) && $stable(r_grad)))
        else $error("stalled result lost or changed");
`endif

endmodule

// File: dv/point_line_distance_gradient_checker.sv
`timescale 1ns / 1ps

module point_line_distance_gradient_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    plg_in_if    in_ch,
    plg_out_if   out_ch,
    plg_cfg_if   cfg_ch,
    output int   o_fail_count,
    output int   o_pending
);
    import plg_pkg::*;

    typedef struct packed {
        logic [31:0] lx;
        logic [31:0] ly;
        logic [31:0] lz;
        logic        inf;
    } t_line_cfg;

    typedef struct packed {
        logic [31:0] distance;
        logic [31:0] grad_entry;
        logic        grad_valid;
    } t_seg_dist;

    t_line_cfg line_cfg;
    t_seg_dist dist_queue[$];
    int        mismatches;

    function automatic logic [63:0] isqrt128(logic [127:0] v);
        logic [127:0] res;
        logic [127:0] bitv;
        res  = '0;
        bitv = 128'd1 << 126;
        while (bitv != 0 && bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res[63:0];
    endfunction

    function automatic t_seg_dist predict_distance(t_line_cfg c, logic [191:0] raw_in);
        logic [31:0]         lraw[3];
        logic [31:0]         lm[3];
        logic [31:0]         pm[3];
        logic [31:0]         vm[3];
        logic                ln[3];
        logic                pn[3];
        logic                vn[3];
        logic [62:0]         dvm[3];
        logic                dvn[3];
        logic signed [131:0] n_acc;
        logic signed [131:0] dot_acc;
        logic signed [131:0] term;
        logic signed [131:0] s;
        logic [127:0]        d;
        logic [127:0]        sq;
        logic [127:0]        q;
        logic [127:0]        mag;
        logic [127:0]        prod;
        logic [62:0]         tq;
        logic                tneg;
        logic [63:0]         root;
        logic [31:0]         glim;
        logic [31:0]         gmag;
        logic                gneg;
        t_seg_dist           r;
        lraw[0] = c.lx;
        lraw[1] = c.ly;
        lraw[2] = c.lz;
        n_acc = '0;
        dot_acc = '0;
        d = '0;
        sq = '0;
        tq = '0;
        tneg = 1'b0;
        for (int i = 0; i < 3; i++) begin
            ln[i] = lraw[i][31];
            lm[i] = ln[i] ? -lraw[i] : lraw[i];
            pn[i] = raw_in[191 - 32*i];
            pm[i] = pn[i] ? -raw_in[191 - 32*i -: 32] : raw_in[191 - 32*i -: 32];
            vn[i] = raw_in[95 - 32*i];
            vm[i] = vn[i] ? -raw_in[95 - 32*i -: 32] : raw_in[95 - 32*i -: 32];
            term = $signed({4'b0, 128'(64'(pm[i]) * 64'(lm[i]))});
            n_acc = (pn[i] != ln[i]) ? n_acc - term : n_acc + term;
            d = d + 128'(64'(lm[i]) * 64'(lm[i]));
        end
        // The projection parameter is only formed for a nonzero line and dot product.
        if (d != 0 && n_acc != 0) begin
            mag = n_acc < 0 ? 128'(-n_acc) : 128'(n_acc);
            q = (mag << 32) / d;
            if (c.inf) begin
                tq = (q > 128'(T_CAP)) ? T_CAP : q[62:0];
                tneg = n_acc < 0;
            end else if (n_acc > 0) begin
                tq = (q > 128'(T_ONE)) ? T_ONE : q[62:0];
            end
        end
        for (int i = 0; i < 3; i++) begin
            prod = (128'(tq) * 128'(lm[i]) + (128'd1 << 31)) >> 32;
            s = $signed({4'b0, prod});
            if (tneg != ln[i]) s = -s;
            s = pn[i] ? s + $signed({100'b0, pm[i]}) : s - $signed({100'b0, pm[i]});
            mag = s < 0 ? 128'(-s) : 128'(s);
            dvm[i] = (mag > 128'(DV_CAP)) ? DV_CAP : mag[62:0];
            dvn[i] = s < 0;
            sq = sq + 128'(dvm[i]) * 128'(dvm[i]);
        end
        if (sq == 0) begin
            r = '0;
        end else begin
            root = isqrt128(sq);
            for (int i = 0; i < 3; i++) begin
                term = $signed({4'b0, 128'(dvm[i]) * 128'(vm[i])});
                dot_acc = (dvn[i] != vn[i]) ? dot_acc - term : dot_acc + term;
            end
            mag = dot_acc < 0 ? 128'(-dot_acc) : 128'(dot_acc);
            q = mag / 128'(root);
            gneg = (dot_acc >= 0) && (q != 0);
            glim = gneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            gmag = (q > 128'(glim)) ? glim : q[31:0];
            r.distance = (root > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
            r.grad_entry = gneg ? -gmag : gmag;
            r.grad_valid = 1'b1;
        end
        return r;
    endfunction

    assign o_fail_count = mismatches;

    always @(posedge i_clk) begin
        t_seg_dist want;
        if (!i_rst_n) begin
            line_cfg <= '{lx: 32'(LINE_X_RST), ly: '0, lz: '0, inf: 1'b0};
            dist_queue.delete();
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_LINE_X:   line_cfg.lx <= cfg_ch.data;
                    CFG_LINE_Y:   line_cfg.ly <= cfg_ch.data;
                    CFG_LINE_Z:   line_cfg.lz <= cfg_ch.data;
                    CFG_INF_MODE: line_cfg.inf <= cfg_ch.data[0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                dist_queue = {dist_queue, predict_distance(line_cfg,
                    {in_ch.point_x, in_ch.point_y, in_ch.point_z,
                     in_ch.vel_x, in_ch.vel_y, in_ch.vel_z})};
            end
            if (out_ch.valid && out_ch.ready) begin
                if (dist_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: distance %h grad %h valid %b",
                                 out_ch.distance, out_ch.grad_entry, out_ch.grad_valid);
                end else begin
                    want = dist_queue.pop_front();
                    if (want.distance !== out_ch.distance ||
                        want.grad_entry !== out_ch.grad_entry ||
                        want.grad_valid !== out_ch.grad_valid) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected dist %h grad %h valid %b, got %h %h %b",
                                     want.distance, want.grad_entry, want.grad_valid,
                                     out_ch.distance, out_ch.grad_entry, out_ch.grad_valid);
                    end
                end
            end
        end
        o_pending <= dist_queue.size();
    end

endmodule

// File: dv/point_line_distance_gradient_test.sv
`timescale 1ns / 1ps

module point_line_distance_gradient_test;
    import plg_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 220;
    localparam int ITEMS_PER_PHASE = 325;
    localparam int LONG_HOLD_CYCLES = 600;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    bit   no_gaps;
    bit   hold_request;
    bit   hold_done;

    plg_in_if  #(.COORD_BITS(32)) in_ch ();
    plg_out_if #(.COORD_BITS(32)) out_ch ();
    plg_cfg_if #(.COORD_BITS(32)) cfg_ch ();

    point_line_distance_gradient #(.COORD_BITS(32)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    point_line_distance_gradient_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_ch       (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Gap lengths: mostly none or a few cycles, now and then a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Field values lean toward the extremes and small magnitudes, where the
    // clamping and saturation paths live.
    function automatic logic [31:0] pick_coord();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = '0;
            3, 4: begin
                v = $urandom_range(0, 32'h0010_0000);
                if ($urandom_range(0, 1)) v = -v;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Valid stays high from one write to the next; the caller lowers it.
    task automatic write_reg(t_cfg_idx idx, logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic set_line(logic [31:0] lx, logic [31:0] ly, logic [31:0] lz, logic inf);
        write_reg(CFG_LINE_X, lx);
        write_reg(CFG_LINE_Y, ly);
        write_reg(CFG_LINE_Z, lz);
        // Upper data bits are don't-care for the mode register, so they get noise.
        write_reg(CFG_INF_MODE, {31'($urandom_range(0, 32'h7FFF_FFFF)), inf});
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // One input transfer; valid is only lowered when a gap follows.
    task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                              logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
        int gap;
        in_ch.valid   <= 1'b1;
        in_ch.point_x <= px;
        in_ch.point_y <= py;
        in_ch.point_z <= pz;
        in_ch.vel_x   <= vx;
        in_ch.vel_y   <= vy;
        in_ch.vel_z   <= vz;
        do @(posedge i_clk); while (!in_ch.ready);
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_random_points(int count);
        for (int k = 0; k < count; k++)
            send_point(pick_coord(), pick_coord(), pick_coord(),
                       pick_coord(), pick_coord(), pick_coord());
    endtask

    // The block may hold results in flight, so wait for every expected result
    // and then the pipeline depth before touching the registers.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Result side: random back-pressure plus one long hold-off on request.
    initial begin
        out_ch.ready = 1'b0;
        hold_done = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_request && !hold_done) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                out_ch.ready <= (no_gaps || $urandom_range(0, 3) != 0);
                @(posedge i_clk);
                if (!out_ch.ready && !no_gaps && $urandom_range(0, 49) == 0) begin
                    repeat ($urandom_range(10, 60)) @(posedge i_clk);
                end
            end
        end
    end

    // Any cycle without a transfer on some channel counts toward the timeout.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[point_line_distance_gradient] ERROR");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        no_gaps = 1'b0;
        hold_request = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.point_x = '0;
        in_ch.point_y = '0;
        in_ch.point_z = '0;
        in_ch.vel_x = '0;
        in_ch.vel_y = '0;
        in_ch.vel_z = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_LINE_X;
        cfg_ch.data = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items against the reset line, a unit segment along x.
        // A point on the segment gives zero distance and no gradient.
        send_point(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0);
        send_point(32'h0000_8000, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0);
        // Beyond the far end and behind the origin, where t clamps.
        send_point(32'h0005_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0);
        send_point(32'hFFFB_0000, 32'h0, 32'hFFFF_0000, 32'h0, 32'h0, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h0, 32'h0003_0000, 32'h0, 32'h0, 32'h8000_0000, 32'h0);
        send_point(32'h0, 32'h0, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF);
        wait_drained();

        // Zero line vector: distance is simply the norm of the point.
        set_line(32'h0, 32'h0, 32'h0, 1'b0);
        send_point(32'h0, 32'h0, 32'h0, 32'h1234_5678, 32'h0, 32'h0);
        send_point(32'h0002_0000, 32'hFFFE_0000, 32'h0001_0000, 32'h0001_0000,
                   32'h0, 32'h0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h7FFF_FFFF);
        send_random_points(ITEMS_PER_PHASE - 20);
        wait_drained();

        // Extreme line in infinite mode; here the result side holds off for a
        // long stretch so that the pipeline fills and stalls its input.
        set_line(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        send_point(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000,
                   32'h0, 32'h0);
        hold_request = 1'b1;
        send_random_points(ITEMS_PER_PHASE);
        wait_drained();

        // Tiny line in infinite mode pushes t into its saturation limit.
        set_line(32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 1'b1);
        send_point(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0);
        send_point(32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
        no_gaps = 1'b1;
        send_random_points(ITEMS_PER_PHASE);
        no_gaps = 1'b0;
        wait_drained();

        // Random lines and modes for the rest of the run.
        for (int ph = 0; ph < 3; ph++) begin
            set_line(pick_coord(), pick_coord(), pick_coord(), 1'($urandom_range(0, 1)));
            send_random_points(ITEMS_PER_PHASE);
            wait_drained();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("[point_line_distance_gradient] OK");
        end else begin
            $display("[point_line_distance_gradient] ERROR");
        end
        $finish;
    end

endmodule
